@@ design/ccfr_pkg.sv @@
// Shared constants, types and the CRC-16/MODBUS byte step for the frame receiver.
package ccfr_pkg;

    localparam int MAX_BODY_DFLT    = 32;
    localparam int QUEUE_DEPTH_DFLT = 8;

    localparam int BYTE_W      = 8;
    localparam int EVENT_W     = 2;
    localparam int ERR_W       = 16;
    localparam int CRC_W       = 16;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY = 16'hA001;
    localparam logic [BYTE_W-1:0] MIN_LENGTH = 8'd2;

    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'h55;

    typedef logic [EVENT_W-1:0] t_event;
    localparam t_event EV_NONE     = 2'd0;
    localparam t_event EV_STORED   = 2'd1;
    localparam t_event EV_DROPPED  = 2'd2;
    localparam t_event EV_MISMATCH = 2'd3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HEADER_FIRST  = 1'b0,
        REG_HEADER_SECOND = 1'b1
    } t_reg_index;

    // One byte of the reflected CRC: eight shift-and-xor steps.
    function automatic logic [CRC_W-1:0] crc16_step(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int i = 0; i < BYTE_W; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ design/ccfr_in_if.sv @@
// Input channel: one beat carries an operation and a received byte.
interface ccfr_in_if;
    logic                           valid;
    logic                           ready;
    logic                           op;
    logic [ccfr_pkg::BYTE_W-1:0]    rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

@@ design/ccfr_out_if.sv @@
// Result channel: one beat carries one result of a feed or a pop.
interface ccfr_out_if #(
    parameter int MAX_BODY    = ccfr_pkg::MAX_BODY_DFLT,
    parameter int QUEUE_DEPTH = ccfr_pkg::QUEUE_DEPTH_DFLT
);
    localparam int LW = $clog2(MAX_BODY + 1);
    localparam int IW = $clog2(MAX_BODY);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    logic                           valid;
    logic                           ready;
    ccfr_pkg::t_event               event_res;
    logic                           frame_found;
    logic [LW-1:0]                  frame_length;
    logic [IW-1:0]                  byte_index;
    logic [ccfr_pkg::BYTE_W-1:0]    frame_byte;
    logic                           last;
    logic [ccfr_pkg::ERR_W-1:0]     error_count;
    logic [FW-1:0]                  frames_waiting;

    modport source (output valid, output event_res, output frame_found,
                    output frame_length, output byte_index, output frame_byte,
                    output last, output error_count, output frames_waiting,
                    input ready);
    modport sink   (input valid, input event_res, input frame_found,
                    input frame_length, input byte_index, input frame_byte,
                    input last, input error_count, input frames_waiting,
                    output ready);
endinterface

@@ design/ccfr_cfg_if.sv @@
// Configuration write channel: one beat writes one header register.
interface ccfr_cfg_if;
    logic                           valid;
    logic                           ready;
    ccfr_pkg::t_reg_index           index;
    logic [ccfr_pkg::BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/ccfr_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
module ccfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ design/crc_checked_frame_receiver.sv @@
// Top level: header hunt, length/body/CRC parser and a frame queue held in RAM.
//
//  Channel   Dir   Beat contents                                      Handshake
//  i_in      in    op (0 feed byte, 1 pop frame), rx_byte             valid/ready
//  o_out     out   event_res, frame_found, frame_length, byte_index,  valid/ready
//                  frame_byte, last, error_count, frames_waiting
//  i_cfg     in    index (0 header_first, 1 header_second), data      valid/ready
//
// A feed beat is accepted in S_IDLE and parsed in S_FEED, which updates the
// CRC and writes the body byte into the queue RAM. A pop beat of an N-byte
// frame streams from the byte RAM read port at one body byte per cycle while
// the output register is free. An empty pop gives a single not-found result.
// Reset clears the parser, pointers, fill and error count at once; the RAMs
// are not cleared since no entry is read before it is written.
// A stalled result holds in the output register; the next item is accepted
// while it waits, and the block stalls only if a second result is ready.
module crc_checked_frame_receiver #(
    parameter int MAX_BODY    = ccfr_pkg::MAX_BODY_DFLT,
    parameter int QUEUE_DEPTH = ccfr_pkg::QUEUE_DEPTH_DFLT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ccfr_in_if.sink     i_in,
    ccfr_cfg_if.sink    i_cfg,
    ccfr_out_if.source  o_out
);
    import ccfr_pkg::*;

    // Body index, length and fill widths follow from the two parameters.
    localparam int IW         = $clog2(MAX_BODY);
    localparam int LW         = $clog2(MAX_BODY + 1);
    localparam int FW         = $clog2(QUEUE_DEPTH + 1);
    // One row more than the queue holds: the incoming frame always owns a
    // spare row, so a frame that fails its CRC never disturbs a queued one.
    localparam int ROWS       = QUEUE_DEPTH + 1;
    localparam int RW         = $clog2(ROWS);
    localparam int BYTE_DEPTH = ROWS * (2 ** IW);
    localparam int BAW        = RW + IW;

    localparam logic [BYTE_W-1:0] MAX_LEN_B = BYTE_W'(MAX_BODY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FEED,
        S_POP_HEAD,
        S_POP_BODY
    } t_state;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_HEAD2,
        PH_LEN,
        PH_BODY,
        PH_CRC_L,
        PH_CRC_H
    } t_phase;

    // Ring of physical rows; wraps after the spare row.
    function automatic logic [RW-1:0] row_next(input logic [RW-1:0] row);
        return (row == RW'(QUEUE_DEPTH)) ? '0 : row + RW'(1);
    endfunction

    t_state               r_state, n_state;
    t_phase               r_phase, n_phase;
    logic [BYTE_W-1:0]    r_hdr_first, n_hdr_first;
    logic [BYTE_W-1:0]    r_hdr_second, n_hdr_second;
    logic [LW-1:0]        r_exp_len, n_exp_len;
    logic [LW-1:0]        r_body_count, n_body_count;
    logic [BYTE_W-1:0]    r_crc_low, n_crc_low;
    logic [CRC_W-1:0]     r_crc, n_crc;
    logic [RW-1:0]        r_wp, n_wp;
    logic [RW-1:0]        r_rp, n_rp;
    logic [FW-1:0]        r_fill, n_fill;
    logic [ERR_W-1:0]     r_err, n_err;

    // Item and pop stream registers.
    logic [BYTE_W-1:0]    r_byte, n_byte;
    logic [RW-1:0]        r_row, n_row;
    logic [IW-1:0]        r_ridx, n_ridx;
    logic [LW-1:0]        r_len, n_len;

    // Output register.
    logic                 r_out_valid, n_out_valid;
    t_event               r_out_event, n_out_event;
    logic                 r_out_found, n_out_found;
    logic [LW-1:0]        r_out_len, n_out_len;
    logic [IW-1:0]        r_out_idx, n_out_idx;
    logic [BYTE_W-1:0]    r_out_byte, n_out_byte;
    logic                 r_out_last, n_out_last;
    logic [ERR_W-1:0]     r_out_err, n_out_err;
    logic [FW-1:0]        r_out_fill, n_out_fill;

    // RAM ports.
    logic                 byte_we;
    logic [BAW-1:0]       byte_waddr;
    logic [BAW-1:0]       byte_raddr;
    logic [BYTE_W-1:0]    byte_rdata;
    logic                 len_we;
    logic [LW-1:0]        len_rdata;

    logic                 out_free;
    logic                 pop_last;
    t_event               ev;

    assign out_free    = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign byte_waddr = {r_wp, r_body_count[IW-1:0]};
    // The read address follows the next pointers so that the registered data
    // always belongs to the byte that the stream registers point at.
    assign byte_raddr = {n_row, n_ridx};

    ccfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BYTE_DEPTH)
    ) u_byte_ram (
        .i_clk   (i_clk),
        .i_we    (byte_we),
        .i_waddr (byte_waddr),
        .i_wdata (r_byte),
        .i_raddr (byte_raddr),
        .o_rdata (byte_rdata)
    );

    ccfr_ram #(
        .WIDTH (LW),
        .DEPTH (ROWS)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (r_wp),
        .i_wdata (r_exp_len),
        .i_raddr (r_rp),
        .o_rdata (len_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_hdr_first  = r_hdr_first;
        n_hdr_second = r_hdr_second;
        n_exp_len    = r_exp_len;
        n_body_count = r_body_count;
        n_crc_low    = r_crc_low;
        n_crc        = r_crc;
        n_wp         = r_wp;
        n_rp         = r_rp;
        n_fill       = r_fill;
        n_err        = r_err;
        n_byte       = r_byte;
        n_row        = r_row;
        n_ridx       = r_ridx;
        n_len        = r_len;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_event  = r_out_event;
        n_out_found  = r_out_found;
        n_out_len    = r_out_len;
        n_out_idx    = r_out_idx;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;
        n_out_err    = r_out_err;
        n_out_fill   = r_out_fill;
        byte_we      = 1'b0;
        len_we       = 1'b0;
        ev           = EV_NONE;
        pop_last     = 1'b0;

        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_HEADER_FIRST:  n_hdr_first  = i_cfg.data;
                REG_HEADER_SECOND: n_hdr_second = i_cfg.data;
                default:           n_hdr_first  = r_hdr_first;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_byte = i_in.rx_byte;
                    if (i_in.op) begin
                        n_state = S_POP_HEAD;
                        n_row   = r_rp;
                        n_ridx  = '0;
                    end else begin
                        n_state = S_FEED;
                    end
                end
            end

            S_FEED: begin
                if (out_free) begin
                    unique case (r_phase)
                        PH_HUNT: begin
                            if (r_byte == r_hdr_first) begin
                                n_phase = PH_HEAD2;
                            end
                        end
                        PH_HEAD2: begin
                            // The second header wins when both headers are equal.
                            if (r_byte == r_hdr_second) begin
                                n_phase = PH_LEN;
                            end else if (r_byte != r_hdr_first) begin
                                n_phase = PH_HUNT;
                            end
                        end
                        PH_LEN: begin
                            if (r_byte < MIN_LENGTH || r_byte > MAX_LEN_B) begin
                                n_phase = PH_HUNT;
                            end else begin
                                n_exp_len    = r_byte[LW-1:0];
                                n_body_count = '0;
                                n_crc        = crc16_step(CRC_INIT, r_byte);
                                n_phase      = PH_BODY;
                            end
                        end
                        PH_BODY: begin
                            byte_we      = 1'b1;
                            n_crc        = crc16_step(r_crc, r_byte);
                            n_body_count = r_body_count + LW'(1);
                            if (n_body_count >= r_exp_len) begin
                                n_phase = PH_CRC_L;
                            end
                        end
                        PH_CRC_L: begin
                            n_crc_low = r_byte;
                            n_phase   = PH_CRC_H;
                        end
                        PH_CRC_H: begin
                            if ({r_byte, r_crc_low} == r_crc) begin
                                // Commit the spare row and its length.
                                len_we = 1'b1;
                                n_wp   = row_next(r_wp);
                                if (r_fill < FW'(QUEUE_DEPTH)) begin
                                    n_fill = r_fill + FW'(1);
                                    ev     = EV_STORED;
                                end else begin
                                    n_rp = row_next(r_rp);
                                    ev   = EV_DROPPED;
                                end
                            end else begin
                                n_err = r_err + ERR_W'(1);
                                ev    = EV_MISMATCH;
                            end
                            n_phase = PH_HUNT;
                        end
                        default: n_phase = PH_HUNT;
                    endcase

                    n_out_valid = 1'b1;
                    n_out_event = ev;
                    n_out_found = 1'b0;
                    n_out_len   = '0;
                    n_out_idx   = '0;
                    n_out_byte  = '0;
                    n_out_last  = 1'b1;
                    n_out_err   = n_err;
                    n_out_fill  = n_fill;
                    n_state     = S_IDLE;
                end
            end

            S_POP_HEAD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_event = EV_NONE;
                    n_out_err   = r_err;
                    n_out_idx   = '0;
                    if (r_fill == '0) begin
                        n_out_found = 1'b0;
                        n_out_len   = '0;
                        n_out_byte  = '0;
                        n_out_last  = 1'b1;
                        n_out_fill  = r_fill;
                        n_state     = S_IDLE;
                    end else begin
                        pop_last    = (len_rdata == LW'(1));
                        n_len       = len_rdata;
                        n_ridx      = IW'(1);
                        n_rp        = row_next(r_rp);
                        n_fill      = r_fill - FW'(1);
                        n_out_found = 1'b1;
                        n_out_len   = len_rdata;
                        n_out_byte  = byte_rdata;
                        n_out_last  = pop_last;
                        n_out_fill  = n_fill;
                        n_state     = pop_last ? S_IDLE : S_POP_BODY;
                    end
                end
            end

            S_POP_BODY: begin
                if (out_free) begin
                    pop_last    = (LW'(r_ridx) == r_len - LW'(1));
                    n_ridx      = r_ridx + IW'(1);
                    n_out_valid = 1'b1;
                    n_out_event = EV_NONE;
                    n_out_found = 1'b1;
                    n_out_len   = r_len;
                    n_out_idx   = r_ridx;
                    n_out_byte  = byte_rdata;
                    n_out_last  = pop_last;
                    n_out_err   = r_err;
                    n_out_fill  = r_fill;
                    if (pop_last) begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= PH_HUNT;
            r_hdr_first  <= HEADER_FIRST_RST;
            r_hdr_second <= HEADER_SECOND_RST;
            r_exp_len    <= '0;
            r_body_count <= '0;
            r_crc_low    <= '0;
            r_crc        <= CRC_INIT;
            r_wp         <= '0;
            r_rp         <= '0;
            r_fill       <= '0;
            r_err        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_hdr_first  <= n_hdr_first;
            r_hdr_second <= n_hdr_second;
            r_exp_len    <= n_exp_len;
            r_body_count <= n_body_count;
            r_crc_low    <= n_crc_low;
            r_crc        <= n_crc;
            r_wp         <= n_wp;
            r_rp         <= n_rp;
            r_fill       <= n_fill;
            r_err        <= n_err;
            r_out_valid  <= n_out_valid;
        end
        r_byte      <= n_byte;
        r_row       <= n_row;
        r_ridx      <= n_ridx;
        r_len       <= n_len;
        r_out_event <= n_out_event;
        r_out_found <= n_out_found;
        r_out_len   <= n_out_len;
        r_out_idx   <= n_out_idx;
        r_out_byte  <= n_out_byte;
        r_out_last  <= n_out_last;
        r_out_err   <= n_out_err;
        r_out_fill  <= n_out_fill;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.event_res      = r_out_event;
    assign o_out.frame_found    = r_out_found;
    assign o_out.frame_length   = r_out_len;
    assign o_out.byte_index     = r_out_idx;
    assign o_out.frame_byte     = r_out_byte;
    assign o_out.last           = r_out_last;
    assign o_out.error_count    = r_out_err;
    assign o_out.frames_waiting = r_out_fill;
endmodule
